@@ hw/rtl/siaalu_pkg.sv @@
// shared types and codes for the saturating integer alu
package siaalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_EQ  = 4'd5,
		OP_NE  = 4'd6,
		OP_LT  = 4'd7,
		OP_LE  = 4'd8,
		OP_GT  = 4'd9,
		OP_GE  = 4'd10,
		OP_NEG = 4'd11
	} siaalu_op_t;

	// where the final value of an item comes from
	typedef enum logic [1:0] {
		SRC_EARLY,
		SRC_MUL,
		SRC_DIV,
		SRC_MOD
	} siaalu_src_t;

	typedef struct packed {
		siaalu_src_t src;
		logic        cmp;
		logic        arith;
		logic        qneg;
		logic        rneg;
	} siaalu_side_t;

endpackage

@@ hw/rtl/siaalu_req_if.sv @@
// request channel: opcode and two operands
interface siaalu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [63:0] operand_a;
	logic [63:0] operand_b;

	modport source (output valid, req_type, operand_a, operand_b, input ready);
	modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

@@ hw/rtl/siaalu_rsp_if.sv @@
// response channel: value, compare outcome and special flag
interface siaalu_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_out;
	logic        compare_true;
	logic        is_special;

	modport source (output valid, value_out, compare_true, is_special, input ready);
	modport sink (input valid, value_out, compare_true, is_special, output ready);
endinterface

@@ hw/rtl/siaalu_mul.sv @@
// three stage saturating magnitude multiplier built from four partial products
module siaalu_mul #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-2:0] ma,
	input  logic [W-2:0] mb,
	output logic [W-2:0] mag
);
	localparam int H  = W / 2;
	localparam int HI = W - 1 - H;
	localparam int PW = 2 * (W - 1);
	localparam logic [PW-1:0] POS_MAG = PW'({(W-1){1'b1}});

	logic [2*HI-1:0]  pp_hh_s1;
	logic [HI+H-1:0]  pp_hl_s1;
	logic [HI+H-1:0]  pp_lh_s1;
	logic [2*H-1:0]   pp_ll_s1;
	logic [PW-1:0]    prod_s2;
	logic [W-2:0]     mag_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_hh_s1 <= ma[W-2:H] * mb[W-2:H];
			pp_hl_s1 <= ma[W-2:H] * mb[H-1:0];
			pp_lh_s1 <= ma[H-1:0] * mb[W-2:H];
			pp_ll_s1 <= ma[H-1:0] * mb[H-1:0];
			prod_s2  <= (PW'(pp_hh_s1) << (2 * H))
				+ ((PW'(pp_hl_s1) + PW'(pp_lh_s1)) << H)
				+ PW'(pp_ll_s1);
			mag_s3   <= (prod_s2 > POS_MAG) ? {(W-1){1'b1}} : prod_s2[W-2:0];
		end
	end

	assign mag = mag_s3;
endmodule

@@ hw/rtl/siaalu_div.sv @@
// restoring magnitude divider, one quotient bit per pipeline stage
module siaalu_div #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] dvd,
	input  logic [W-1:0] dsr,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	logic [W-1:0] rem_s [1:W];
	logic [W-1:0] dvd_s [1:W];
	logic [W-1:0] dsr_s [1:W];
	logic [W-1:0] quo_s [1:W];

	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [W-1:0] rem_p, dvd_p, dsr_p, quo_p;
		logic [W:0]   trial;
		logic [W:0]   diff;
		logic         ge;

		if (k == 1) begin : g_first
			assign rem_p = '0;
			assign dvd_p = dvd;
			assign dsr_p = dsr;
			assign quo_p = '0;
		end else begin : g_rest
			assign rem_p = rem_s[k-1];
			assign dvd_p = dvd_s[k-1];
			assign dsr_p = dsr_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign trial = {rem_p, dvd_p[W-1]};
		assign diff  = trial - {1'b0, dsr_p};
		assign ge    = !diff[W];

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				dvd_s[k] <= {dvd_p[W-2:0], 1'b0};
				dsr_s[k] <= dsr_p;
				quo_s[k] <= {quo_p[W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[W];
	assign rem = rem_s[W];
endmodule

@@ hw/rtl/saturating_int_alu_inf_nan_top.sv @@
// top level of the saturating integer alu with nan and infinity codes
// Signed DATA_WIDTH-bit alu where the most negative code is NaN, the next is minus
// infinity and the most positive is plus infinity; operands are the low DATA_WIDTH
// bits of the 64-bit request fields and the value is returned sign-extended to 64
// bits. One request enters per cycle unless the pipeline holds. Each result passes
// the input register, the divider stages (one quotient bit per stage) and the output
// register; the multiplier and simple operations ride in delay lines to keep order.
// The whole pipeline holds while a result waits on the response side.
module saturating_int_alu_inf_nan_top #(
	parameter int DATA_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	siaalu_req_if.sink     req,
	siaalu_rsp_if.source   rsp
);
	import siaalu_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] POS_INF  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NAN_CODE = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] NEG_INF  = {1'b1, {(W-2){1'b0}}, 1'b1};

	function automatic logic spec(input logic [W-1:0] v);
		return v == NAN_CODE || v == NEG_INF || v == POS_INF;
	endfunction

	function automatic logic [W-1:0] neg(input logic [W-1:0] v);
		return (v == NAN_CODE) ? NAN_CODE : W'(-v);
	endfunction

	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// input register
	logic              valid_s1;
	logic [3:0]        op_s1;
	logic signed [W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= req.req_type;
			a_s1  <= req.operand_a[W-1:0];
			b_s1  <= req.operand_b[W-1:0];
		end
	end

	// magnitudes for the multiplier and divider
	logic [W-1:0] ma, mb;
	assign ma = a_s1[W-1] ? W'(-a_s1) : a_s1;
	assign mb = b_s1[W-1] ? W'(-b_s1) : b_s1;

	// early results and routing
	siaalu_side_t      side_c;
	logic [W-1:0]      val_c;
	logic [W-1:0]      bs;
	logic signed [W:0] sum;
	logic              has_nan, eq, lt;

	always_comb begin
		bs      = (siaalu_op_t'(op_s1) == OP_SUB) ? neg(b_s1) : b_s1;
		sum     = {a_s1[W-1], a_s1} + {bs[W-1], bs};
		has_nan = a_s1 == NAN_CODE || b_s1 == NAN_CODE;
		eq      = a_s1 == b_s1;
		lt      = a_s1 < b_s1;
		side_c  = '{src: SRC_EARLY, cmp: 1'b0, arith: 1'b1,
			qneg: a_s1[W-1] ^ b_s1[W-1], rneg: a_s1[W-1]};
		val_c   = '0;
		unique case (op_s1)
			OP_ADD, OP_SUB: begin
				if (a_s1 == POS_INF) begin
					val_c = (bs == NEG_INF || bs == NAN_CODE) ? NAN_CODE : POS_INF;
				end else if (a_s1 == NAN_CODE) begin
					val_c = NAN_CODE;
				end else if (a_s1 == NEG_INF) begin
					val_c = (bs == POS_INF || bs == NAN_CODE) ? NAN_CODE : NEG_INF;
				end else if (spec(bs)) begin
					val_c = bs;
				end else if (sum >= $signed({1'b0, POS_INF})) begin
					val_c = POS_INF;
				end else if (sum <= $signed({1'b1, NEG_INF})) begin
					val_c = NEG_INF;
				end else begin
					val_c = sum[W-1:0];
				end
			end
			OP_MUL: begin
				if (a_s1 == '0) begin
					val_c = spec(b_s1) ? NAN_CODE : '0;
				end else if (a_s1 == NAN_CODE) begin
					val_c = NAN_CODE;
				end else if (a_s1 == POS_INF || a_s1 == NEG_INF) begin
					if (b_s1 == NAN_CODE || b_s1 == '0) val_c = NAN_CODE;
					else val_c = b_s1[W-1] ? neg(a_s1) : a_s1;
				end else if (b_s1 == '0) begin
					val_c = '0;
				end else if (b_s1 == NAN_CODE) begin
					val_c = NAN_CODE;
				end else if (b_s1 == POS_INF) begin
					val_c = a_s1[W-1] ? NEG_INF : POS_INF;
				end else if (b_s1 == NEG_INF) begin
					val_c = a_s1[W-1] ? POS_INF : NEG_INF;
				end else begin
					side_c.src = SRC_MUL;
				end
			end
			OP_DIV: begin
				if (b_s1 == POS_INF || b_s1 == NEG_INF) begin
					val_c = spec(a_s1) ? NAN_CODE : '0;
				end else if (b_s1 == NAN_CODE) begin
					val_c = NAN_CODE;
				end else if (b_s1 == '0) begin
					if (spec(a_s1)) val_c = a_s1;
					else if (a_s1 == '0) val_c = NAN_CODE;
					else val_c = a_s1[W-1] ? NEG_INF : POS_INF;
				end else if (a_s1 == '0 || a_s1 == NAN_CODE) begin
					val_c = a_s1;
				end else if (a_s1 == POS_INF || a_s1 == NEG_INF) begin
					val_c = b_s1[W-1] ? W'(-a_s1) : a_s1;
				end else begin
					side_c.src = SRC_DIV;
				end
			end
			OP_MOD: begin
				if (spec(b_s1) || b_s1 == '0 || spec(a_s1)) val_c = NAN_CODE;
				else side_c.src = SRC_MOD;
			end
			OP_EQ: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !has_nan && eq;
			end
			OP_NE: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !(!has_nan && eq);
			end
			OP_LT: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !has_nan && lt;
			end
			OP_LE: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !has_nan && (lt || eq);
			end
			OP_GT: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !has_nan && !(lt || eq);
			end
			OP_GE: begin
				side_c.arith = 1'b0;
				side_c.cmp   = !has_nan && !lt;
			end
			OP_NEG: val_c = neg(a_s1);
			default: side_c.arith = 1'b0;
		endcase
	end

	// delay lines matched to the divider depth
	logic         v_s    [1:W];
	siaalu_side_t side_s [1:W];
	logic [W-1:0] val_s  [1:W];
	logic [W-2:0] mm_s   [4:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= W; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= valid_s1;
			for (int k = 2; k <= W; k++) v_s[k] <= v_s[k-1];
		end
	end

	logic [W-2:0] mul_mag;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_c;
			val_s[1]  <= val_c;
			for (int k = 2; k <= W; k++) begin
				side_s[k] <= side_s[k-1];
				val_s[k]  <= val_s[k-1];
			end
			mm_s[4] <= mul_mag;
			for (int k = 5; k <= W; k++) mm_s[k] <= mm_s[k-1];
		end
	end

	siaalu_mul #(.W(W)) u_mul (
		.clk (clk),
		.adv (adv),
		.ma  (ma[W-2:0]),
		.mb  (mb[W-2:0]),
		.mag (mul_mag)
	);

	logic [W-1:0] quo, rem;

	siaalu_div #(.W(W)) u_div (
		.clk (clk),
		.adv (adv),
		.dvd (ma),
		.dsr (mb),
		.quo (quo),
		.rem (rem)
	);

	// final sign fixup and output register
	logic [W-1:0] mag_f, val_f;
	logic         sneg;

	always_comb begin
		unique case (side_s[W].src)
			SRC_MUL: begin
				mag_f = {1'b0, mm_s[W]};
				sneg  = side_s[W].qneg;
			end
			SRC_DIV: begin
				mag_f = quo;
				sneg  = side_s[W].qneg;
			end
			SRC_MOD: begin
				mag_f = rem;
				sneg  = side_s[W].rneg;
			end
			default: begin
				mag_f = val_s[W];
				sneg  = 1'b0;
			end
		endcase
		val_f = sneg ? W'(-mag_f) : mag_f;
	end

	logic signed [W-1:0] value_q;
	logic                cmp_q, special_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q   <= val_f;
			cmp_q     <= side_s[W].cmp;
			special_q <= side_s[W].arith && spec(val_f);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.value_out    = 64'(value_q);
	assign rsp.compare_true = cmp_q;
	assign rsp.is_special   = special_q;
endmodule

@@ bench/tb_saturating_int_alu_inf_nan_top.sv @@
// testbench for the saturating integer alu: random and directed transfers checked against a predictor
`timescale 1ns / 1ps

module tb_saturating_int_alu_inf_nan_top;
	import siaalu_pkg::*;

	localparam int DW = 64;
	localparam int LATENCY = DW + 2;
	localparam int WATCHDOG = 20000;
	localparam logic signed [63:0] POS_INF = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] NEG_INF = -POS_INF;
	localparam logic signed [63:0] NAN_CODE = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic [3:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct {
		logic [63:0] value;
		logic        cmp;
		logic        spec;
	} alu_rsp_t;

	logic clk;
	logic arst_n;

	siaalu_req_if req ();
	siaalu_rsp_if rsp ();

	saturating_int_alu_inf_nan_top #(.DATA_WIDTH(DW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	alu_req_t pending_reqs[$];
	alu_rsp_t expected_rsps[$];
	int       fail_count = 0;
	bit       pause_sender;
	bit       hold_start;
	int       hold_rsp;
	int       idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit is_spec(logic signed [63:0] v);
		return v == NAN_CODE || v == NEG_INF || v == POS_INF;
	endfunction

	function automatic logic signed [63:0] negate(logic signed [63:0] v);
		return v == NAN_CODE ? NAN_CODE : -v;
	endfunction

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
			logic signed [63:0] b);
		if (a == POS_INF)
			return (b == NEG_INF || b == NAN_CODE) ? NAN_CODE : POS_INF;
		if (a == NAN_CODE)
			return NAN_CODE;
		if (a == NEG_INF)
			return (b == POS_INF || b == NAN_CODE) ? NAN_CODE : NEG_INF;
		if (is_spec(b))
			return b;
		if (b >= 0)
			return (a < POS_INF - b) ? a + b : POS_INF;
		return (a > NEG_INF - b) ? a + b : NEG_INF;
	endfunction

	function automatic logic signed [63:0] sat_mul(logic signed [63:0] a,
			logic signed [63:0] b);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] prod;
		logic signed [63:0] mag;
		if (a == 0)
			return is_spec(b) ? NAN_CODE : 64'sd0;
		if (a == NAN_CODE)
			return NAN_CODE;
		if (a == POS_INF || a == NEG_INF) begin
			if (b == NAN_CODE || b == 0)
				return NAN_CODE;
			return b < 0 ? negate(a) : a;
		end
		if (b == 0)
			return 64'sd0;
		if (b == NAN_CODE)
			return NAN_CODE;
		if (b == POS_INF)
			return a < 0 ? NEG_INF : POS_INF;
		if (b == NEG_INF)
			return a < 0 ? POS_INF : NEG_INF;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		prod = ma * mb;
		mag = (prod >= 128'(POS_INF)) ? POS_INF : prod[63:0];
		return ((a < 0) != (b < 0)) ? -mag : mag;
	endfunction

	function automatic logic signed [63:0] sat_div(logic signed [63:0] a,
			logic signed [63:0] b);
		if (b == POS_INF || b == NEG_INF)
			return is_spec(a) ? NAN_CODE : 64'sd0;
		if (b == NAN_CODE)
			return NAN_CODE;
		if (b == 0) begin
			if (is_spec(a))
				return a;
			if (a == 0)
				return NAN_CODE;
			return a > 0 ? POS_INF : NEG_INF;
		end
		if (a == 0 || a == NAN_CODE)
			return a;
		if (a == POS_INF || a == NEG_INF)
			return b < 0 ? -a : a;
		return a / b;
	endfunction

	function automatic alu_rsp_t alu_result(alu_req_t r);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] v;
		bit cmp;
		bit arith;
		bit has_nan;
		alu_rsp_t res;
		a = r.a;
		b = r.b;
		v = 0;
		cmp = 0;
		arith = 1;
		has_nan = (a == NAN_CODE || b == NAN_CODE);
		case (r.op)
			OP_ADD: v = sat_add(a, b);
			OP_SUB: v = sat_add(a, negate(b));
			OP_MUL: v = sat_mul(a, b);
			OP_DIV: v = sat_div(a, b);
			OP_MOD: v = (is_spec(b) || b == 0 || is_spec(a)) ? NAN_CODE : a % b;
			OP_EQ: begin arith = 0; cmp = !has_nan && a == b; end
			OP_NE: begin arith = 0; cmp = !(!has_nan && a == b); end
			OP_LT: begin arith = 0; cmp = !has_nan && a < b; end
			OP_LE: begin arith = 0; cmp = !has_nan && a <= b; end
			OP_GT: begin arith = 0; cmp = !has_nan && a > b; end
			OP_GE: begin arith = 0; cmp = !has_nan && a >= b; end
			OP_NEG: v = negate(a);
			default: arith = 0;
		endcase
		res.value = v;
		res.cmp = cmp;
		res.spec = arith && is_spec(v);
		return res;
	endfunction

	// operands biased toward codes and edges around them
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return NAN_CODE;
			1: return NEG_INF;
			2: return POS_INF;
			3: return 64'd0;
			4: return 64'($signed($urandom_range(0, 20)) - 10);
			5: return POS_INF - $urandom_range(0, 3);
			6: return NEG_INF + $urandom_range(0, 3);
			7: return {$urandom, $urandom} >> $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_req(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		alu_req_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	// driver
	int  send_gap;
	bit  drain_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= '0;
			req.operand_a <= '0;
			req.operand_b <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_rsps.push_back(alu_result('{req.req_type, req.operand_a,
					req.operand_b}));
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !pause_sender) begin
					alu_req_t r;
					r = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.req_type <= r.op;
					req.operand_a <= r.a;
					req.operand_b <= r.b;
					send_gap <= $urandom_range(0, 3);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and response stalls
	int rsp_gap;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_gap <= 0;
			idle_cycles <= 0;
			hold_rsp <= 0;
			hold_done <= 1'b0;
		end else begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected transfer value_out=%h", rsp.value_out);
					fail_count++;
				end else begin
					alu_rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.value_out !== e.value) begin
						$error("value_out expected %h actual %h", e.value, rsp.value_out);
						fail_count++;
					end
					if (rsp.compare_true !== e.cmp) begin
						$error("compare_true expected %b actual %b", e.cmp,
							rsp.compare_true);
						fail_count++;
					end
					if (rsp.is_special !== e.spec) begin
						$error("is_special expected %b actual %b", e.spec, rsp.is_special);
						fail_count++;
					end
				end
			end
			if (hold_start && !hold_done) begin
				hold_done <= 1'b1;
				hold_rsp <= 200;
				rsp.ready <= 1'b0;
			end else if (hold_rsp > 0) begin
				hold_rsp <= hold_rsp - 1;
				rsp.ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp.valid && rsp.ready)
					rsp_gap <= $urandom_range(0, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && idle_cycles >= WATCHDOG) begin
			$display("tb_saturating_int_alu_inf_nan_top: FAIL");
			$finish;
		end
	end

	initial begin
		logic [63:0] edges[7];
		pause_sender = 0;
		hold_start = 0;
		arst_n = 1'b0;
		edges = '{NAN_CODE, NEG_INF, POS_INF, 64'd0, 64'd1, -64'sd1, 64'd7};

		// directed: every operation over the edge codes
		for (int op = 0; op < 16; op++)
			push_req(4'(op), edges[op % 7], edges[(op * 3 + 1) % 7]);
		push_req(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
		push_req(OP_MUL, -64'sh1_0000_0000, 64'h0000_0001_0000_0000);
		push_req(OP_DIV, 64'd0, 64'd0);
		push_req(OP_DIV, -64'sd5, 64'd0);
		push_req(OP_DIV, POS_INF, -64'sd3);
		push_req(OP_MOD, -64'sd7, 64'd3);
		push_req(OP_ADD, POS_INF - 1, 64'd1);
		push_req(OP_SUB, NEG_INF + 1, 64'd1);
		push_req(OP_NE, NAN_CODE, NAN_CODE);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);

		for (int i = 0; i < 300; i++)
			push_req(4'($urandom_range(0, 15)), pick_operand(), pick_operand());

		// long response hold while requests keep coming, so the pipe backs up
		@(posedge clk);
		hold_start = 1;
		wait (pending_reqs.size() == 0);

		// sender pauses until everything has drained
		pause_sender = 1;
		wait (expected_rsps.size() == 0);
		@(posedge clk);
		pause_sender = 0;

		for (int i = 0; i < 325; i++)
			push_req(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (req.valid) @(posedge clk);
		wait (expected_rsps.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		if (fail_count == 0 && expected_rsps.size() == 0)
			$display("tb_saturating_int_alu_inf_nan_top: PASS");
		else
			$display("tb_saturating_int_alu_inf_nan_top: FAIL");
		$finish;
	end

endmodule

@@ saturating_int_alu_inf_nan_top.f @@
hw/rtl/siaalu_pkg.sv
hw/rtl/siaalu_req_if.sv
hw/rtl/siaalu_rsp_if.sv
hw/rtl/siaalu_mul.sv
hw/rtl/siaalu_div.sv
hw/rtl/saturating_int_alu_inf_nan_top.sv
bench/tb_saturating_int_alu_inf_nan_top.sv
